### sv/v3alu_pkg.sv
// ----------------------------------------------------------------------------
// v3alu_pkg: shared types for the fixed point vector alu
// Opcodes, status codes, result types and the saturating clamp helpers.
// ----------------------------------------------------------------------------
package v3alu_pkg;

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_SCALE = 4'd3,
        OP_DIV   = 4'd4,
        OP_ADDS  = 4'd5,
        OP_DOT   = 4'd6,
        OP_CROSS = 4'd7,
        OP_LENSQ = 4'd8,
        OP_LEN   = 4'd9,
        OP_UNIT  = 4'd10
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    // clamped 32-bit value and its saturation flag
    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } satv_t;

    // result fields, vector x in the lowest bits
    typedef struct packed {
        logic [31:0]      so;
        logic [2:0][31:0] r;
    } res_t;

    // what the front end hands to the root and divide pipelines
    typedef struct packed {
        op_t              op;
        res_t             res;
        logic             sat;
        logic [63:0]      rad;
        logic [2:0][31:0] amag;
        logic [2:0]       aneg;
        logic [31:0]      smag;
        logic             sneg;
        logic             divz;
    } front_t;

    // clamp a sign-magnitude value into the signed 32-bit range
    function automatic satv_t sat_sm(input logic neg, input logic [63:0] mag);
        satv_t r;
        r.sat = 1'b0;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                r.val = 32'h8000_0000;
                r.sat = 1'b1;
            end else begin
                r.val = 32'(64'd0 - mag);
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                r.val = 32'h7FFF_FFFF;
                r.sat = 1'b1;
            end else begin
                r.val = mag[31:0];
            end
        end
        return r;
    endfunction

    // clamp a 33-bit two's complement sum
    function automatic satv_t add_sat(input logic [32:0] s);
        logic [32:0] m;
        m = s[32] ? 33'd0 - s : s;
        return sat_sm(s[32], 64'(m));
    endfunction

endpackage

### sv/v3alu_front.sv
// ----------------------------------------------------------------------------
// v3alu_front: operand select, multiply and accumulate
// Five register stages: capture, operand magnitudes and add ops, six
// 32x32 products, signed sums, then truncate and saturate.
// ----------------------------------------------------------------------------
module v3alu_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [3:0]         in_op,
    input  logic [2:0][31:0]   in_a,
    input  logic [2:0][31:0]   in_b,
    input  logic [31:0]        in_s,
    output logic               out_valid,
    output v3alu_pkg::front_t  out_data
);
    import v3alu_pkg::*;

    typedef struct packed {
        logic [3:0]       op;
        logic [2:0][31:0] a;
        logic [2:0][31:0] b;
        logic [31:0]      s;
    } sta_t;

    typedef struct packed {
        op_t              op;
        res_t             addr;
        logic             add_sat;
        logic [2:0][31:0] amag;
        logic [2:0]       aneg;
        logic [31:0]      smag;
        logic             sneg;
        logic             divz;
    } cry_t;

    typedef struct packed {
        cry_t             c;
        logic [5:0][31:0] xm;
        logic [5:0][31:0] ym;
        logic [5:0]       pn;
    } stb_t;

    typedef struct packed {
        cry_t             c;
        logic [5:0][63:0] p;
        logic [5:0]       pn;
    } stc_t;

    typedef struct packed {
        cry_t             c;
        logic [2:0][65:0] lane;
        logic [65:0]      sum;
    } std_t;

    logic   a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    sta_t   a_reg, a_next;
    stb_t   b_reg, b_next;
    stc_t   c_reg, c_next;
    std_t   d_reg, d_next;
    front_t e_reg, e_next;

    function automatic satv_t fix66(input logic [65:0] v);
        logic [65:0] m;
        logic [63:0] sh;
        m  = v[65] ? 66'd0 - v : v;
        sh = m[63:0] >> FRAC_BITS;
        return sat_sm(v[65], sh);
    endfunction

    assign a_next.op = in_op;
    assign a_next.a  = in_a;
    assign a_next.b  = in_b;
    assign a_next.s  = in_s;

    // magnitudes, product operand pairs and the plain add ops
    always_comb begin
        logic [2:0][31:0] ma, mb;
        logic [2:0]       an, bn;
        logic [31:0]      ms;
        logic             sn;
        logic [32:0]      s33;
        satv_t            sv;
        op_t              op;
        logic             is_add;
        op     = op_t'(a_reg.op);
        sn     = a_reg.s[31];
        ms     = sn ? 32'd0 - a_reg.s : a_reg.s;
        is_add = (op == OP_ADD) || (op == OP_SUB) || (op == OP_ADDS);
        b_next = '0;
        for (int i = 0; i < 3; i++) begin
            an[i] = a_reg.a[i][31];
            bn[i] = a_reg.b[i][31];
            ma[i] = an[i] ? 32'd0 - a_reg.a[i] : a_reg.a[i];
            mb[i] = bn[i] ? 32'd0 - a_reg.b[i] : a_reg.b[i];
        end
        b_next.c.op   = op;
        b_next.c.amag = ma;
        b_next.c.aneg = an;
        b_next.c.smag = ms;
        b_next.c.sneg = sn;
        b_next.c.divz = (a_reg.s == 32'd0);
        for (int i = 0; i < 3; i++) begin
            case (op)
                OP_SUB:  s33 = {a_reg.a[i][31], a_reg.a[i]} - {a_reg.b[i][31], a_reg.b[i]};
                OP_ADDS: s33 = {a_reg.a[i][31], a_reg.a[i]} + {a_reg.s[31], a_reg.s};
                default: s33 = {a_reg.a[i][31], a_reg.a[i]} + {a_reg.b[i][31], a_reg.b[i]};
            endcase
            sv = add_sat(s33);
            if (is_add) begin
                b_next.c.addr.r[i] = sv.val;
                b_next.c.add_sat   = b_next.c.add_sat | sv.sat;
            end
        end
        case (op)
            OP_MUL, OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    b_next.xm[i] = ma[i];
                    b_next.ym[i] = mb[i];
                    b_next.pn[i] = an[i] ^ bn[i];
                end
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    b_next.xm[i] = ma[i];
                    b_next.ym[i] = ms;
                    b_next.pn[i] = an[i] ^ sn;
                end
            end
            OP_LENSQ, OP_LEN, OP_UNIT: begin
                for (int i = 0; i < 3; i++) begin
                    b_next.xm[i] = ma[i];
                    b_next.ym[i] = ma[i];
                end
            end
            OP_CROSS: begin
                // lane i = p[i] - p[i+3]
                b_next.xm[0] = ma[1]; b_next.ym[0] = mb[2]; b_next.pn[0] = an[1] ^ bn[2];
                b_next.xm[3] = ma[2]; b_next.ym[3] = mb[1]; b_next.pn[3] = ~(an[2] ^ bn[1]);
                b_next.xm[1] = ma[2]; b_next.ym[1] = mb[0]; b_next.pn[1] = an[2] ^ bn[0];
                b_next.xm[4] = ma[0]; b_next.ym[4] = mb[2]; b_next.pn[4] = ~(an[0] ^ bn[2]);
                b_next.xm[2] = ma[0]; b_next.ym[2] = mb[1]; b_next.pn[2] = an[0] ^ bn[1];
                b_next.xm[5] = ma[1]; b_next.ym[5] = mb[0]; b_next.pn[5] = ~(an[1] ^ bn[0]);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        c_next.c  = b_reg.c;
        c_next.pn = b_reg.pn;
        for (int k = 0; k < 6; k++) begin
            c_next.p[k] = 64'(b_reg.xm[k]) * 64'(b_reg.ym[k]);
        end
    end

    always_comb begin
        logic [5:0][65:0] t;
        for (int k = 0; k < 6; k++) begin
            t[k] = c_reg.pn[k] ? 66'd0 - {2'b00, c_reg.p[k]} : {2'b00, c_reg.p[k]};
        end
        d_next.c = c_reg.c;
        for (int i = 0; i < 3; i++) begin
            d_next.lane[i] = t[i] + t[i + 3];
        end
        d_next.sum = t[0] + t[1] + t[2];
    end

    always_comb begin
        satv_t [2:0] lv;
        satv_t       sv;
        for (int i = 0; i < 3; i++) begin
            lv[i] = fix66(d_reg.lane[i]);
        end
        sv          = fix66(d_reg.sum);
        e_next      = '0;
        e_next.op   = d_reg.c.op;
        e_next.rad  = d_reg.sum[63:0];
        e_next.amag = d_reg.c.amag;
        e_next.aneg = d_reg.c.aneg;
        e_next.smag = d_reg.c.smag;
        e_next.sneg = d_reg.c.sneg;
        e_next.divz = d_reg.c.divz;
        case (d_reg.c.op)
            OP_ADD, OP_SUB, OP_ADDS: begin
                e_next.res = d_reg.c.addr;
                e_next.sat = d_reg.c.add_sat;
            end
            OP_MUL, OP_SCALE, OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    e_next.res.r[i] = lv[i].val;
                end
                e_next.sat = lv[0].sat | lv[1].sat | lv[2].sat;
            end
            OP_DOT, OP_LENSQ: begin
                e_next.res.so = sv.val;
                e_next.sat    = sv.sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_data  = e_reg;

endmodule

### sv/v3alu_sqrt.sv
// ----------------------------------------------------------------------------
// v3alu_sqrt: pipelined floor square root of a 64-bit radicand
// One root bit per stage, 32 stages, side payload travels alongside.
// ----------------------------------------------------------------------------
module v3alu_sqrt #(
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [63:0]   in_rad,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [31:0]   out_root,
    output logic [PW-1:0] out_pay
);
    localparam int NST = 32;

    logic [NST-1:0]         vld_reg;
    logic [NST-1:0][33:0]   rem_reg, rem_next;
    logic [NST-1:0][31:0]   root_reg, root_next;
    logic [NST-1:0][63:0]   rad_reg, rad_next;
    logic [NST-1:0][PW-1:0] pay_reg, pay_next;

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic [33:0] rem_in, cur, trial;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic        ge;
        if (k == 0) begin : g_first
            assign rem_in      = '0;
            assign root_in     = '0;
            assign rad_in      = in_rad;
            assign pay_next[k] = in_pay;
        end else begin : g_rest
            assign rem_in      = rem_reg[k-1];
            assign root_in     = root_reg[k-1];
            assign rad_in      = rad_reg[k-1];
            assign pay_next[k] = pay_reg[k-1];
        end
        // bring down two radicand bits, try 4r+1
        assign cur          = {rem_in[31:0], rad_in[63:62]};
        assign trial        = {root_in, 2'b01};
        assign ge           = cur >= trial;
        assign rem_next[k]  = ge ? cur - trial : cur;
        assign root_next[k] = {root_in[30:0], ge};
        assign rad_next[k]  = {rad_in[61:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
            pay_reg  <= pay_next;
        end
    end

    assign out_valid = vld_reg[NST-1];
    assign out_root  = root_reg[NST-1];
    assign out_pay   = pay_reg[NST-1];

endmodule

### sv/v3alu_div.sv
// ----------------------------------------------------------------------------
// v3alu_div: three-lane pipelined restoring divider
// One quotient bit per stage, DW stages, common 32-bit divisor.
// ----------------------------------------------------------------------------
module v3alu_div #(
    parameter int DW = 48,
    parameter int PW = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [2:0][DW-1:0]   in_dvd,
    input  logic [31:0]          in_dsr,
    input  logic [PW-1:0]        in_pay,
    output logic                 out_valid,
    output logic [2:0][DW-1:0]   out_quot,
    output logic [PW-1:0]        out_pay
);
    logic [DW-1:0]                vld_reg;
    logic [DW-1:0][2:0][31:0]     rem_reg, rem_next;
    logic [DW-1:0][2:0][DW-1:0]   sh_reg, sh_next;
    logic [DW-1:0][31:0]          dsr_reg, dsr_next;
    logic [DW-1:0][PW-1:0]        pay_reg, pay_next;

    for (genvar k = 0; k < DW; k++) begin : g_st
        logic [2:0][31:0]   rem_in;
        logic [2:0][DW-1:0] sh_in;
        logic [31:0]        dsr_in;
        if (k == 0) begin : g_first
            assign rem_in      = '0;
            assign sh_in       = in_dvd;
            assign dsr_in      = in_dsr;
            assign pay_next[k] = in_pay;
        end else begin : g_rest
            assign rem_in      = rem_reg[k-1];
            assign sh_in       = sh_reg[k-1];
            assign dsr_in      = dsr_reg[k-1];
            assign pay_next[k] = pay_reg[k-1];
        end
        assign dsr_next[k] = dsr_in;
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [32:0] cur;
            logic        ge;
            // dividend bits leave at the top, quotient bits enter at the bottom
            assign cur             = {rem_in[l], sh_in[l][DW-1]};
            assign ge              = cur >= {1'b0, dsr_in};
            assign rem_next[k][l]  = ge ? 32'(cur - {1'b0, dsr_in}) : cur[31:0];
            assign sh_next[k][l]   = {sh_in[l][DW-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            sh_reg  <= sh_next;
            dsr_reg <= dsr_next;
            pay_reg <= pay_next;
        end
    end

    assign out_valid = vld_reg[DW-1];
    assign out_quot  = sh_reg[DW-1];
    assign out_pay   = pay_reg[DW-1];

endmodule

### sv/vector3_fixed_point_alu_core.sv
// ----------------------------------------------------------------------------
// vector3_fixed_point_alu_core: pipelined three-component fixed point alu
//
//  channel | dir | tdata (low bit first)                   | tuser
//  s_axis  | in  | ax, ay, az, bx, by, bz, scalar_in (224) | op (4)
//  m_axis  | out | rx, ry, rz, scalar_out (128)            | status (2)
//
// One beat per cycle in and out while no stall holds the pipeline. A beat passes
// through the front multiply stages, one stage per root bit, then one stage per
// quotient bit of the divider, and then the output register.
// Reset clears the valid bits of every stage, the output register and the skid
// register; the data registers are left as they are.
// A full skid register freezes the whole pipeline; s_axis_tready is its
// registered inverse, so nothing is lost or repeated on a stall.
// ----------------------------------------------------------------------------
module vector3_fixed_point_alu_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [223:0] s_axis_tdata,   // ax, ay, az, bx, by, bz, scalar_in
    input  logic [3:0]   s_axis_tuser,   // op
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // rx, ry, rz, scalar_out
    output logic [1:0]   m_axis_tuser    // status
);
    import v3alu_pkg::*;

    localparam int DW = 32 + FRAC_BITS;

    typedef struct packed {
        front_t      f;
        logic [31:0] root;
    } dpay_t;

    typedef struct packed {
        res_t    res;
        status_t st;
    } out_t;

    logic               adv;
    logic               fr_valid, sq_valid, dv_valid;
    front_t             fr_data, sq_f;
    logic [31:0]        sq_root;
    logic [2:0][DW-1:0] dv_dvd, dv_quot;
    logic [31:0]        dv_dsr;
    dpay_t              dv_in, dp;
    out_t               res_next;
    out_t               out_data_reg, skid_data_reg;
    logic               out_valid_reg, skid_valid_reg;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    v3alu_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_a      (s_axis_tdata[95:0]),
        .in_b      (s_axis_tdata[191:96]),
        .in_s      (s_axis_tdata[223:192]),
        .out_valid (fr_valid),
        .out_data  (fr_data)
    );

    v3alu_sqrt #(
        .PW($bits(front_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_rad    (fr_data.rad),
        .in_pay    (fr_data),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_pay   (sq_f)
    );

    // unit vector divides by the length, div by the scalar magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_dvd[i] = {sq_f.amag[i], {FRAC_BITS{1'b0}}};
        end
        dv_dsr     = (sq_f.op == OP_UNIT) ? sq_root : sq_f.smag;
        dv_in.f    = sq_f;
        dv_in.root = sq_root;
    end

    v3alu_div #(
        .DW(DW),
        .PW($bits(dpay_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_dvd    (dv_dvd),
        .in_dsr    (dv_dsr),
        .in_pay    (dv_in),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_pay   (dp)
    );

    always_comb begin
        satv_t [2:0] qv;
        satv_t       lv;
        logic        qneg;
        logic        zdiv;
        logic        sat;
        for (int i = 0; i < 3; i++) begin
            qneg  = (dp.f.op == OP_DIV) ? (dp.f.aneg[i] ^ dp.f.sneg) : dp.f.aneg[i];
            qv[i] = sat_sm(qneg, 64'(dv_quot[i]));
        end
        lv       = sat_sm(1'b0, 64'(dp.root));
        res_next = '0;
        zdiv     = 1'b0;
        sat      = 1'b0;
        case (dp.f.op)
            OP_DIV, OP_UNIT: begin
                zdiv = (dp.f.op == OP_DIV) ? dp.f.divz : (dp.root == 32'd0);
                if (!zdiv) begin
                    for (int i = 0; i < 3; i++) begin
                        res_next.res.r[i] = qv[i].val;
                    end
                    sat = qv[0].sat | qv[1].sat | qv[2].sat;
                end
            end
            OP_LEN: begin
                res_next.res.so = lv.val;
                sat             = lv.sat;
            end
            default: begin
                res_next.res = dp.f.res;
                sat          = dp.f.sat;
            end
        endcase
        res_next.st = zdiv ? ST_DIVZ : (sat ? ST_SAT : ST_OK);
    end

    // output register with a skid stage behind it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (dv_valid) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (dv_valid) begin
            if (!out_valid_reg || m_axis_tready) begin
                out_data_reg <= res_next;
            end else begin
                skid_data_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg.res;
    assign m_axis_tuser  = out_data_reg.st;

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_axis_tvalid)
        else $error("skid holds a beat while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_divz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == ST_DIVZ) |-> (m_axis_tdata == 128'd0))
        else $error("division by zero beat carries nonzero data");

endmodule
